// ----- src/olad_pkg.sv -----
`default_nettype none

package olad_pkg;

  localparam int DefaultDepth = 64;
  localparam int DataW        = 32;
  localparam int PosW         = 6;
  localparam int CntW         = 7;
  localparam int StatusW      = 3;

  localparam logic ActAppend = 1'b0;
  localparam logic ActDelete = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StAppended = 3'd0,
    StDeleted  = 3'd1,
    StNotFound = 3'd2,
    StEmpty    = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SOp,
    SScan,
    SShift
  } state_e;

  // Per-cell controls: load takes the key, capture latches the compare,
  // scan moves match flags toward the head, shift moves data toward the head.
  typedef struct packed {
    logic load;
    logic capture;
    logic scan;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/olad_cell.sv -----
`default_nettype none

module olad_cell (
  input  wire                           clk_i,
  input  wire  olad_pkg::cell_ctrl_t    ctrl_i,
  input  wire  [olad_pkg::DataW-1:0]    key_i,
  input  wire  [olad_pkg::DataW-1:0]    next_data_i,
  input  wire                           next_match_i,
  output logic [olad_pkg::DataW-1:0]    data_o,
  output logic                          match_o
);
  import olad_pkg::*;

  logic [DataW-1:0] data_q;
  logic             match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= key_i;
    end else if (ctrl_i.shift) begin
      data_q <= next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      match_q <= (data_q == key_i);
    end else if (ctrl_i.scan) begin
      match_q <= next_match_i;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ----- src/ordered_list_append_delete_first_unit.sv -----
`default_nettype none

// Ordered list of signed 32-bit values with append at the tail and removal
// of the first entry (from the head) equal to a search value.
// Command channel: a transaction (action_i, value_i) is taken at a rising
// edge with start_i high and busy_o low. busy_o stays high until the result
// is registered. Each transaction gives one result, shown on status_o,
// position_o and count_o for exactly one cycle while result_valid_o is high;
// the receiver cannot stall, so the result is simply taken in that cycle.
// Storage is a row of DEPTH cells; each cell holds one entry and hands data
// and match flags to its head-side neighbor.
// Sequence: append, full and delete on an empty list give their result from
// SOp; a delete on a non-empty list captures the compare in SOp, scans in
// SScan until a hit or the last held entry, and on a hit removes the entry
// in SShift by moving the entries behind it toward the head.
// The match scan walks the cell row one position per cycle, and a new
// transaction is taken only after the result of the last one is registered.
// A new transaction may be started in the cycle the result strobe is high.
// Reset clears the entry count and the control state; cell contents are not
// cleared and are read only after they have been written.
module ordered_list_append_delete_first_unit #(
  parameter int DEPTH = olad_pkg::DefaultDepth
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  output logic                              busy_o,
  input  wire  [0:0]                        action_i,
  input  wire  signed [olad_pkg::DataW-1:0] value_i,
  output logic                              result_valid_o,
  output logic [olad_pkg::StatusW-1:0]      status_o,
  output logic [olad_pkg::PosW-1:0]         position_o,
  output logic [olad_pkg::CntW-1:0]         count_o
);
  import olad_pkg::*;

  localparam int IdxW  = $clog2(DEPTH);
  localparam int CntIW = $clog2(DEPTH + 1);

  state_e               state_q, state_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CntIW-1:0]     count_q, count_d;
  logic [DataW-1:0]     key_q;
  logic                 act_q;

  logic                 rv_q, rv_d;
  status_e              status_q, res_status;
  logic [PosW-1:0]      pos_q;
  logic [CntW-1:0]      cnt_q;
  logic [IdxW-1:0]      res_pos;
  logic [CntIW-1:0]     res_cnt;

  logic                 do_load, do_shift, do_capture, do_scan;
  logic                 is_full, is_empty, scan_last;
  logic                 accept;

  logic [DataW-1:0]     data_w [DEPTH+1];
  logic [DEPTH:0]       match_w;

  logic [PosW+IdxW-1:0]   pos_ext;
  logic [CntW+CntIW-1:0]  cnt_ext;

  assign accept    = start_i && (state_q == SIdle);
  assign busy_o    = (state_q != SIdle);
  assign is_full   = (count_q == CntIW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign scan_last = ((CntIW'(idx_q) + CntIW'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  // Hold the command for the whole transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= $unsigned(value_i);
      act_q <= action_i[0];
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    count_d    = count_q;
    rv_d       = 1'b0;
    res_status = StAppended;
    res_pos    = '0;
    res_cnt    = count_q;
    do_load    = 1'b0;
    do_shift   = 1'b0;
    do_capture = 1'b0;
    do_scan    = 1'b0;
    case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = SOp;
        end
      end
      SOp: begin
        if (act_q == ActAppend) begin
          rv_d    = 1'b1;
          state_d = SIdle;
          if (is_full) begin
            res_status = StFull;
          end else begin
            do_load    = 1'b1;
            count_d    = count_q + CntIW'(1);
            res_status = StAppended;
            res_pos    = count_q[IdxW-1:0];
            res_cnt    = count_q + CntIW'(1);
          end
        end else if (is_empty) begin
          rv_d       = 1'b1;
          res_status = StEmpty;
          state_d    = SIdle;
        end else begin
          do_capture = 1'b1;
          idx_d      = '0;
          state_d    = SScan;
        end
      end
      SScan: begin
        if (match_w[0]) begin
          state_d = SShift;
        end else if (scan_last) begin
          rv_d       = 1'b1;
          res_status = StNotFound;
          state_d    = SIdle;
        end else begin
          do_scan = 1'b1;
          idx_d   = idx_q + IdxW'(1);
        end
      end
      SShift: begin
        do_shift   = 1'b1;
        count_d    = count_q - CntIW'(1);
        rv_d       = 1'b1;
        res_status = StDeleted;
        res_pos    = idx_q;
        res_cnt    = count_q - CntIW'(1);
        state_d    = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Fields wider than the ports report their low bits.
  assign pos_ext = {{PosW{1'b0}}, res_pos};
  assign cnt_ext = {{CntW{1'b0}}, res_cnt};

  always_ff @(posedge clk_i) begin
    if (rv_d) begin
      status_q <= res_status;
      pos_q    <= pos_ext[PosW-1:0];
      cnt_q    <= cnt_ext[CntW-1:0];
    end
  end

  assign result_valid_o = rv_q;
  assign status_o       = status_q;
  assign position_o     = pos_q;
  assign count_o        = cnt_q;

  // Tail end of the row feeds zeros.
  assign data_w[DEPTH]  = '0;
  assign match_w[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;

    always_comb begin
      ctrl.load    = do_load && (count_q == CntIW'(i));
      ctrl.capture = do_capture;
      ctrl.scan    = do_scan;
      ctrl.shift   = do_shift && (IdxW'(i) >= idx_q);
    end

    olad_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_i        (key_q),
      .next_data_i  (data_w[i+1]),
      .next_match_i (match_w[i+1]),
      .data_o       (data_w[i]),
      .match_o      (match_w[i])
    );
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntIW'(DEPTH))
    else $error("entry count beyond depth");

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == SIdle))
    else $error("result strobe while a transaction is still running");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> (CntIW'(idx_q) < count_q))
    else $error("scan index past the held entries");

  a_delete_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SShift) |=> (count_q == $past(count_q) - CntIW'(1)))
    else $error("delete did not drop the entry count");

endmodule

`default_nettype wire
